// File: hdl/rgb_status_led_animator_defines.svh
// Assertion macros for the RGB status LED animator checker.
// No dependencies; the caller provides a clock named clock.
`ifndef RGB_STATUS_LED_ANIMATOR_DEFINES_SVH
`define RGB_STATUS_LED_ANIMATOR_DEFINES_SVH

// Same-cycle implication.
`define RSLA_ASSERT_NOW(label, dis, ante, cons) \
   label: assert property (@(posedge clock) disable iff (dis) (ante) |-> (cons)) \
      else $error("rsla check failed");

// Next-cycle implication.
`define RSLA_ASSERT_NEXT(label, dis, ante, cons) \
   label: assert property (@(posedge clock) disable iff (dis) (ante) |=> (cons)) \
      else $error("rsla check failed");

`endif

// File: hdl/rsla_pkg.sv
// Shared types and codes for the RGB status LED animator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsla_pkg;

   localparam int LEVEL_W  = 8;
   localparam int DUTY_W   = 7;
   localparam int COLOR_W  = 3;
   localparam int KIND_W   = 3;
   localparam int HOLD_W   = 5;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   localparam logic [KIND_W-1:0] NOTE_OK         = 3'd0;
   localparam logic [KIND_W-1:0] NOTE_INFO       = 3'd1;
   localparam logic [KIND_W-1:0] NOTE_WARNING    = 3'd2;
   localparam logic [KIND_W-1:0] NOTE_PANIC      = 3'd3;
   localparam logic [KIND_W-1:0] NOTE_IDLE       = 3'd4;
   localparam logic [KIND_W-1:0] NOTE_LAST_VALID = 3'd6;

   localparam logic [KIND_W-1:0] ANIM_NONE       = 3'd0;
   localparam logic [KIND_W-1:0] ANIM_SLOW_FADE  = 3'd1;
   localparam logic [KIND_W-1:0] ANIM_FAST_FADE  = 3'd2;
   localparam logic [KIND_W-1:0] ANIM_SLOW_BLINK = 3'd3;
   localparam logic [KIND_W-1:0] ANIM_FAST_BLINK = 3'd4;
   localparam logic [KIND_W-1:0] ANIM_LAST_VALID = 3'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP       = 8'd255;
   localparam logic [LEVEL_W-1:0] STEP_SLOW_FADE  = 8'd5;
   localparam logic [LEVEL_W-1:0] STEP_FAST_FADE  = 8'd20;
   localparam logic [LEVEL_W-1:0] STEP_BLINK      = 8'd255;

   localparam logic [HOLD_W-1:0] HOLD_FADE        = 5'd1;
   localparam logic [HOLD_W-1:0] HOLD_SLOW_RISE   = 5'd10;
   localparam logic [HOLD_W-1:0] HOLD_SLOW_FALL   = 5'd20;
   localparam logic [HOLD_W-1:0] HOLD_FAST_RISE   = 5'd2;
   localparam logic [HOLD_W-1:0] HOLD_FAST_FALL   = 5'd4;

   // bit 0 red, bit 1 green, bit 2 blue
   localparam logic [COLOR_W-1:0] MASK_NONE   = 3'b000;
   localparam logic [COLOR_W-1:0] MASK_RED    = 3'b001;
   localparam logic [COLOR_W-1:0] MASK_GREEN  = 3'b010;
   localparam logic [COLOR_W-1:0] MASK_BLUE   = 3'b100;
   localparam logic [COLOR_W-1:0] MASK_YELLOW = 3'b011;
   localparam logic [COLOR_W-1:0] IDLE_FIRST  = 3'd2;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [COLOR_W-1:0] mask;
   } disp_type;

endpackage

`default_nettype wire

// File: hdl/rsla_anim.sv
// Animation state: notification, mode, level, phase, hold counter, idle color.
// Depends on rsla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsla_anim
   import rsla_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic              cmd,
   input  wire logic [KIND_W-1:0] note,
   input  wire logic [KIND_W-1:0] anim,
   output disp_type               disp,
   output logic                   status
);

   logic [KIND_W-1:0]  cur_note_ff, cur_note_in;
   logic [KIND_W-1:0]  cur_anim_ff, cur_anim_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               falling_ff, falling_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [COLOR_W-1:0] idle_ff, idle_in;

   logic [LEVEL_W-1:0] step;
   logic [HOLD_W-1:0]  hold_lim;
   logic [HOLD_W-1:0]  hold_inc;
   logic [LEVEL_W:0]   sum;
   logic [COLOR_W-1:0] idle_end;

   function automatic logic [LEVEL_W-1:0] anim_step(input logic [KIND_W-1:0] a);
      logic [LEVEL_W-1:0] s;
      case (a)
         ANIM_SLOW_FADE:  s = STEP_SLOW_FADE;
         ANIM_FAST_FADE:  s = STEP_FAST_FADE;
         ANIM_SLOW_BLINK: s = STEP_BLINK;
         ANIM_FAST_BLINK: s = STEP_BLINK;
         default:         s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [HOLD_W-1:0] anim_hold(input logic [KIND_W-1:0] a,
                                                   input logic f);
      logic [HOLD_W-1:0] h;
      case (a)
         ANIM_SLOW_BLINK: h = f ? HOLD_SLOW_FALL : HOLD_SLOW_RISE;
         ANIM_FAST_BLINK: h = f ? HOLD_FAST_FALL : HOLD_FAST_RISE;
         default:         h = HOLD_FADE;
      endcase
      return h;
   endfunction

   function automatic logic [COLOR_W-1:0] lit_mask(input logic [KIND_W-1:0] n,
                                                   input logic [COLOR_W-1:0] ic);
      logic [COLOR_W-1:0] m;
      case (n)
         NOTE_OK:      m = MASK_GREEN;
         NOTE_INFO:    m = MASK_BLUE;
         NOTE_WARNING: m = MASK_YELLOW;
         NOTE_PANIC:   m = MASK_RED;
         NOTE_IDLE:    m = ic;
         default:      m = MASK_NONE;
      endcase
      return m;
   endfunction

   function automatic logic [COLOR_W-1:0] start_color(input logic [KIND_W-1:0] n,
                                                      input logic [COLOR_W-1:0] ic);
      logic [COLOR_W-1:0] c;
      if (n == NOTE_IDLE) begin
         c = (ic == '0) ? IDLE_FIRST : ic;
      end else begin
         c = '0;
      end
      return c;
   endfunction

   always_comb begin
      cur_note_in = cur_note_ff;
      cur_anim_in = cur_anim_ff;
      level_in    = level_ff;
      falling_in  = falling_ff;
      hold_in     = hold_ff;
      idle_in     = idle_ff;
      disp.level  = level_ff;
      disp.mask   = lit_mask(cur_note_ff, idle_ff);
      status      = 1'b0;

      step     = anim_step(cur_anim_ff);
      hold_lim = anim_hold(cur_anim_ff, falling_ff);
      hold_inc = hold_ff + 5'd1;
      sum      = {1'b0, level_ff} + {1'b0, step};
      idle_end = (cur_note_ff == NOTE_IDLE) ? idle_ff + 3'd1 : idle_ff;

      if (cmd == CMD_TICK) begin
         if (hold_inc < hold_lim) begin
            hold_in = hold_inc;
         end else begin
            hold_in = '0;
            if (step != '0) begin
               if (!falling_ff) begin
                  if (sum >= {1'b0, LEVEL_TOP}) begin
                     level_in   = LEVEL_TOP;
                     falling_in = 1'b1;
                  end else begin
                     level_in = sum[LEVEL_W-1:0];
                  end
               end else if (level_ff < step) begin
                  idle_in    = start_color(cur_note_ff, idle_end);
                  level_in   = '0;
                  falling_in = 1'b0;
               end else begin
                  level_in = level_ff - step;
               end
            end
         end
      end else if (note > NOTE_LAST_VALID || anim > ANIM_LAST_VALID) begin
         status = 1'b1;
      end else begin
         cur_note_in = note;
         cur_anim_in = anim;
         idle_in     = start_color(note, idle_end);
         level_in    = '0;
         falling_in  = 1'b0;
         hold_in     = '0;
         disp.level  = '0;
         disp.mask   = lit_mask(note, idle_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_note_ff <= NOTE_OK;
         cur_anim_ff <= ANIM_SLOW_FADE;
         level_ff    <= '0;
         falling_ff  <= 1'b0;
         hold_ff     <= '0;
         idle_ff     <= '0;
      end else if (fire) begin
         cur_note_ff <= cur_note_in;
         cur_anim_ff <= cur_anim_in;
         level_ff    <= level_in;
         falling_ff  <= falling_in;
         hold_ff     <= hold_in;
         idle_ff     <= idle_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rsla_duty.sv
// Level to active-low PWM duty scaling for the three colors.
// Depends on rsla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsla_duty
   import rsla_pkg::*;
#(
   parameter int DUTY_SCALE = 100
) (
   input  wire disp_type       disp,
   output logic [DUTY_W-1:0]   red_duty,
   output logic [DUTY_W-1:0]   green_duty,
   output logic [DUTY_W-1:0]   blue_duty
);

   localparam logic [LEVEL_W-1:0] SCALE = LEVEL_W'(DUTY_SCALE);

   logic [2*LEVEL_W-1:0] prod;
   logic [2*LEVEL_W:0]   quot_sum;
   logic [LEVEL_W-1:0]   quot;
   logic [LEVEL_W-1:0]   on_val;
   logic [DUTY_W-1:0]    on_duty;
   logic [DUTY_W-1:0]    off_duty;

   // x / 255 for x below 65535: (x + (x >> 8) + 1) >> 8
   always_comb begin
      prod     = disp.level * SCALE;
      quot_sum = {1'b0, prod} + {{(LEVEL_W+1){1'b0}}, prod[2*LEVEL_W-1:LEVEL_W]}
                 + {{(2*LEVEL_W){1'b0}}, 1'b1};
      quot     = quot_sum[2*LEVEL_W-1:LEVEL_W];
      on_val   = SCALE - quot;
      on_duty  = on_val[DUTY_W-1:0];
      off_duty = SCALE[DUTY_W-1:0];

      red_duty   = disp.mask[0] ? on_duty : off_duty;
      green_duty = disp.mask[1] ? on_duty : off_duty;
      blue_duty  = disp.mask[2] ? on_duty : off_duty;
   end

endmodule

`default_nettype wire

// File: hdl/rgb_status_led_animator.sv
// RGB status LED animator: input register, animation state, duty scaling, output register.
// An accepted request beat waits in the input register until the output can move.
// Throughput: one beat per cycle; the output register holds a stalled result
// and the input register keeps accepting as long as the output can move.
// Reset (synchronous, active high) empties both stages and restores the ok / slow fade state.
// Depends on rsla_pkg, rsla_anim and rsla_duty.
`timescale 1ns / 1ps
`default_nettype none

module rgb_status_led_animator
   import rsla_pkg::*;
#(
   parameter int DUTY_SCALE = 100
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [2:0] note_kind, [5:3] anim_kind, [7:6] zero
   input  wire logic        req_tuser,   // [0] command

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [6:0] red_duty, [13:7] green_duty,
                                         // [20:14] blue_duty, [23:21] zero
   output logic             rsp_tuser    // [0] status
);

   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [KIND_W-1:0] in_note_ff;
   logic [KIND_W-1:0] in_anim_ff;

   logic              out_valid_ff;
   logic [23:0]       out_data_ff, out_data_in;
   logic              out_user_ff, out_user_in;

   logic              flow;
   logic              fire;
   disp_type          disp;
   logic              status;
   logic [DUTY_W-1:0] red_duty, green_duty, blue_duty;

   assign flow       = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && flow;
   assign req_tready = !in_valid_ff || flow;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_note_ff <= req_tdata[2:0];
         in_anim_ff <= req_tdata[5:3];
      end
   end

   rsla_anim u_anim (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cmd    (in_cmd_ff),
      .note   (in_note_ff),
      .anim   (in_anim_ff),
      .disp   (disp),
      .status (status)
   );

   rsla_duty #(
      .DUTY_SCALE (DUTY_SCALE)
   ) u_duty (
      .disp       (disp),
      .red_duty   (red_duty),
      .green_duty (green_duty),
      .blue_duty  (blue_duty)
   );

   assign out_data_in = {3'b000, blue_duty, green_duty, red_duty};
   assign out_user_in = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (flow) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

// File: hdl/rsla_checker.sv
// Port-level checks for the RGB status LED animator, bound to the top level.
// Depends on rgb_status_led_animator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_status_led_animator_defines.svh"

module rsla_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   `RSLA_ASSERT_NEXT(a_rsp_hold, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `RSLA_ASSERT_NEXT(a_reset_empty, 1'b0, reset, !rsp_tvalid)
   `RSLA_ASSERT_NOW(a_ready_when_empty, reset, !rsp_tvalid, req_tready)
   `RSLA_ASSERT_NOW(a_two_values, reset, rsp_tvalid, rsp_tdata[6:0] == rsp_tdata[13:7] || rsp_tdata[6:0] == rsp_tdata[20:14] || rsp_tdata[13:7] == rsp_tdata[20:14])
   `RSLA_ASSERT_NOW(a_pad_zero, reset, rsp_tvalid, rsp_tdata[23:21] == 3'b000)

endmodule

bind rgb_status_led_animator rsla_checker u_rsla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for rgb_status_led_animator: directed and random tick/update traffic,
// with random source gaps and sink stalls, checked against an in-bench LED animation predictor.
// Depends on rsla_pkg and the rgb_status_led_animator RTL.
`timescale 1ns / 1ps

module testbench;
   import rsla_pkg::*;

   localparam int DUTY_SCALE = 100;
   localparam int IDLE_LIMIT = 2000;

   localparam logic [KIND_W-1:0] NOTE_DEMO    = 3'd5;
   localparam logic [KIND_W-1:0] NOTE_DEBUG   = NOTE_LAST_VALID;
   localparam logic [KIND_W-1:0] NOTE_BAD     = 3'd7;
   localparam logic [KIND_W-1:0] ANIM_BAD_LO  = 3'd5;
   localparam logic [KIND_W-1:0] ANIM_BAD_TOP = 3'd7;

   typedef struct packed {
      logic [DUTY_W-1:0] red;
      logic [DUTY_W-1:0] green;
      logic [DUTY_W-1:0] blue;
      logic              status;
   } duty_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [2:0] note_kind, [5:3] anim_kind, [7:6] zero
   logic        req_tuser = 1'b0; // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [6:0] red, [13:7] green, [20:14] blue, [23:21] zero
   logic        rsp_tuser;        // [0] status

   rgb_status_led_animator #(.DUTY_SCALE(DUTY_SCALE)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state
   logic [KIND_W-1:0]  led_note    = NOTE_OK;
   logic [KIND_W-1:0]  led_anim    = ANIM_SLOW_FADE;
   logic [9:0]         led_level   = '0;
   logic               led_falling = 1'b0;
   logic [HOLD_W-1:0]  led_hold    = '0;
   logic [COLOR_W-1:0] idle_color  = '0;

   duty_beat_type pending_duties[$];

   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_ticks = 0;
   int n_updates = 0;
   int n_rejects = 0;
   int n_cycle_ends = 0;
   int idle_cycles = 0;

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void bump_idle_color();
      if (led_note == NOTE_IDLE) idle_color = idle_color + 1'b1;
   endfunction

   function automatic void restart_cycle();
      if (led_note == NOTE_IDLE) begin
         if (idle_color == '0) idle_color = IDLE_FIRST;
      end else begin
         idle_color = '0;
      end
      led_level   = '0;
      led_falling = 1'b0;
      led_hold    = '0;
   endfunction

   function automatic duty_beat_type show_led(input logic status);
      duty_beat_type beat;
      logic [COLOR_W-1:0] lit;
      int unsigned on_duty;
      case (led_note)
         NOTE_OK:      lit = MASK_GREEN;
         NOTE_INFO:    lit = MASK_BLUE;
         NOTE_WARNING: lit = MASK_YELLOW;
         NOTE_PANIC:   lit = MASK_RED;
         NOTE_IDLE:    lit = idle_color;
         default:      lit = MASK_NONE;
      endcase
      on_duty = DUTY_SCALE - (int'(led_level) * DUTY_SCALE) / 255;
      beat.red    = DUTY_W'(lit[0] ? on_duty : DUTY_SCALE);
      beat.green  = DUTY_W'(lit[1] ? on_duty : DUTY_SCALE);
      beat.blue   = DUTY_W'(lit[2] ? on_duty : DUTY_SCALE);
      beat.status = status;
      return beat;
   endfunction

   function automatic duty_beat_type predict_led_duty(input logic cmd,
                                                      input logic [KIND_W-1:0] note,
                                                      input logic [KIND_W-1:0] anim);
      duty_beat_type beat;
      int unsigned step;
      logic [HOLD_W-1:0] hold_limit;
      if (cmd == CMD_TICK) begin
         n_ticks++;
         beat = show_led(1'b0);
         case (led_anim)
            ANIM_SLOW_FADE:  step = STEP_SLOW_FADE;
            ANIM_FAST_FADE:  step = STEP_FAST_FADE;
            ANIM_SLOW_BLINK: step = STEP_BLINK;
            ANIM_FAST_BLINK: step = STEP_BLINK;
            default:         step = 0;
         endcase
         case (led_anim)
            ANIM_SLOW_BLINK: hold_limit = led_falling ? HOLD_SLOW_FALL : HOLD_SLOW_RISE;
            ANIM_FAST_BLINK: hold_limit = led_falling ? HOLD_FAST_FALL : HOLD_FAST_RISE;
            default:         hold_limit = HOLD_FADE;
         endcase
         led_hold = led_hold + 1'b1;
         if (led_hold >= hold_limit) begin
            led_hold = '0;
            if (step != 0) begin
               if (!led_falling) begin
                  led_level = led_level + step;
                  if (led_level >= LEVEL_TOP) begin
                     led_level   = LEVEL_TOP;
                     led_falling = 1'b1;
                  end
               end else if (led_level < step) begin
                  n_cycle_ends++;
                  bump_idle_color();
                  restart_cycle();
               end else begin
                  led_level = led_level - step;
               end
            end
         end
      end else if (note > NOTE_LAST_VALID || anim > ANIM_LAST_VALID) begin
         n_rejects++;
         beat = show_led(1'b1);
      end else begin
         n_updates++;
         bump_idle_color();
         led_note = note;
         led_anim = anim;
         restart_cycle();
         beat = show_led(1'b0);
      end
      return beat;
   endfunction

   task automatic send_beat(input logic cmd, input logic [KIND_W-1:0] note,
                            input logic [KIND_W-1:0] anim);
      int gap;
      gap = pick_gap(gap_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, anim, note};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_duties.push_back(predict_led_duty(cmd, note, anim));
      n_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_beat(CMD_TICK, KIND_W'($urandom), KIND_W'($urandom));
   endtask

   // update + tick runs, with some rejected updates and fully random beats mixed in
   task automatic run_animations(input int count);
      int target;
      int pick;
      logic [KIND_W-1:0] note;
      logic [KIND_W-1:0] anim;
      target = n_sent + count;
      while (n_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            note = KIND_W'($urandom);
            anim = KIND_W'($urandom);
            if ($urandom_range(1)) note = NOTE_BAD;
            else anim = KIND_W'($urandom_range(ANIM_BAD_LO, ANIM_BAD_TOP));
            send_beat(CMD_UPDATE, note, anim);
         end else if (pick < 12) begin
            send_beat(1'($urandom), KIND_W'($urandom), KIND_W'($urandom));
         end else begin
            note = ($urandom_range(3) == 0) ? NOTE_IDLE : KIND_W'($urandom_range(NOTE_DEBUG));
            anim = KIND_W'($urandom_range(ANIM_LAST_VALID));
            send_beat(CMD_UPDATE, note, anim);
            send_ticks(($urandom_range(9) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 60));
         end
      end
   endtask

   task automatic test_directed();
      gap_pct   = 0;
      stall_pct = 0;
      send_beat(CMD_TICK, NOTE_BAD, ANIM_BAD_TOP);
      send_beat(CMD_TICK, NOTE_OK, ANIM_NONE);
      send_beat(CMD_UPDATE, NOTE_BAD, ANIM_NONE);
      send_beat(CMD_UPDATE, NOTE_OK, ANIM_BAD_TOP);
      send_beat(CMD_UPDATE, NOTE_BAD, ANIM_BAD_LO);
      send_beat(CMD_UPDATE, NOTE_WARNING, ANIM_FAST_FADE);
      send_ticks(2);
      send_beat(CMD_UPDATE, NOTE_INFO, ANIM_SLOW_BLINK);
      send_ticks(1);
      send_beat(CMD_UPDATE, NOTE_IDLE, ANIM_FAST_BLINK);
      send_ticks(11);
      send_beat(CMD_UPDATE, NOTE_PANIC, ANIM_NONE);
      send_ticks(1);
      send_beat(CMD_UPDATE, NOTE_DEBUG, ANIM_SLOW_FADE);
   endtask

   task automatic test_random_traffic();
      gap_pct   = 30;
      stall_pct = 30;
      run_animations(600);
   endtask

   task automatic test_back_to_back();
      gap_pct   = 0;
      stall_pct = 0;
      run_animations(350);
   endtask

   task automatic test_backpressure();
      gap_pct   = 10;
      stall_pct = 70;
      run_animations(350);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap(stall_pct);
      end
   end

   always @(posedge clock) begin : check_duty
      duty_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_duties.size() == 0) begin
            $error("result beat with no prediction pending");
            errors++;
         end else begin
            want = pending_duties.pop_front();
            n_checked++;
            if (rsp_tdata[6:0] !== want.red) begin
               $error("red_duty: expected %0d, got %0d", want.red, rsp_tdata[6:0]);
               errors++;
            end
            if (rsp_tdata[13:7] !== want.green) begin
               $error("green_duty: expected %0d, got %0d", want.green, rsp_tdata[13:7]);
               errors++;
            end
            if (rsp_tdata[20:14] !== want.blue) begin
               $error("blue_duty: expected %0d, got %0d", want.blue, rsp_tdata[20:14]);
               errors++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_back_to_back();
      test_backpressure();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d beats: %0d ticks, %0d updates, %0d rejected updates",
               n_sent, n_ticks, n_updates, n_rejects);
      $display("Checked %0d results over %0d completed animation cycles",
               n_checked, n_cycle_ends);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/rsla_pkg.sv
hdl/rsla_anim.sv
hdl/rsla_duty.sv
hdl/rgb_status_led_animator.sv
hdl/rsla_checker.sv
verif/testbench.sv
